// ----- sv/tsa_pkg.sv -----
// Package for the transmit segment aggregator with ack coalescing.
// Holds request and segment codes, the store entry layout and the
// controller/datapath command and status structs. No dependencies.
package tsa_pkg;

  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_ACK      = 2'd1;
  localparam logic [1:0] KIND_FRAG_ACK = 2'd2;

  // Width of an ack bitmap and of the alignment window.
  localparam int unsigned WIN = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD,
    S_OUT,
    S_ADD,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] session;
    logic [31:0] seq;
    logic [15:0] frag_total;
    logic [15:0] frag_pos;
    logic [15:0] len;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic latch;   // capture the input transaction
    logic merge;   // set one bit in the open ack bitmap
    logic add;     // append a new segment
    logic rd;      // read the store at the drain pointer
    logic step;    // advance the drain pointer
    logic clear;   // empty the store and close the open acks
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       merge;
    logic       pre_flush;
    logic       post_flush;
    logic       empty;
    logic       last;
  } sts_t;

endpackage

// ----- sv/tsa_ctrl.sv -----
// Controller state machine of the transmit segment aggregator.
// Depends on tsa_pkg for the state type and the command/status structs.
module tsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tsa_pkg::sts_t  sts,
  output tsa_pkg::cmd_t  cmd
);

  tsa_pkg::state_t state, state_next;
  logic then_add, then_add_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tsa_pkg::S_IDLE;
      then_add <= 1'b0;
    end else begin
      state    <= state_next;
      then_add <= then_add_next;
    end
  end

  always_comb begin
    state_next    = state;
    then_add_next = then_add;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      tsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = tsa_pkg::S_DECIDE;
        end
      end
      tsa_pkg::S_DECIDE: begin
        case (sts.req)
          tsa_pkg::REQ_TIMEOUT: begin
            then_add_next = 1'b0;
            if (sts.empty) begin
              cmd.clear  = 1'b1;
              state_next = tsa_pkg::S_IDLE;
            end else begin
              state_next = tsa_pkg::S_RD;
            end
          end
          tsa_pkg::REQ_DATA, tsa_pkg::REQ_ACK: begin
            if (sts.merge) begin
              cmd.merge  = 1'b1;
              state_next = tsa_pkg::S_IDLE;
            end else if (sts.pre_flush) begin
              then_add_next = 1'b1;
              if (sts.empty) begin
                cmd.clear  = 1'b1;
                state_next = tsa_pkg::S_ADD;
              end else begin
                state_next = tsa_pkg::S_RD;
              end
            end else begin
              state_next = tsa_pkg::S_ADD;
            end
          end
          default: state_next = tsa_pkg::S_IDLE;
        endcase
      end
      tsa_pkg::S_RD: begin
        cmd.rd     = 1'b1;
        state_next = tsa_pkg::S_OUT;
      end
      tsa_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            cmd.clear  = 1'b1;
            state_next = then_add ? tsa_pkg::S_ADD : tsa_pkg::S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = tsa_pkg::S_RD;
          end
        end
      end
      tsa_pkg::S_ADD: begin
        cmd.add    = 1'b1;
        state_next = tsa_pkg::S_CHECK;
      end
      tsa_pkg::S_CHECK: begin
        if (sts.post_flush) begin
          then_add_next = 1'b0;
          state_next    = tsa_pkg::S_RD;
        end else begin
          state_next = tsa_pkg::S_IDLE;
        end
      end
      default: state_next = tsa_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready && !cmd.add && !cmd.merge)
    else $error("result offered while the controller is busy elsewhere");
  a_add_then_check: assert property (@(posedge clk) disable iff (rst)
    cmd.add |=> state == tsa_pkg::S_CHECK)
    else $error("an add was not followed by the post-add check");
  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && sts.last) |=> !out_valid)
    else $error("drain continued past the last segment");
`endif

endmodule

// ----- sv/tsa_dpath.sv -----
// Datapath of the transmit segment aggregator: segment store, open-ack
// mirrors, byte and segment counters, threshold register and drain pointer.
// Depends on tsa_pkg for the entry layout and the command/status structs.
module tsa_dpath #(
  parameter int unsigned MAX_SEGS          = 32,
  parameter int unsigned DATA_SEG_OVERHEAD = 12,
  parameter int unsigned ACK_SEG_SIZE      = 12,
  parameter int unsigned FRAG_ACK_SEG_SIZE = 16,
  parameter int unsigned MIN_SEG_SIZE      = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic [1:0]    req_type,
  input  logic [31:0]   session_id,
  input  logic [31:0]   seq_num,
  input  logic [15:0]   frag_total,
  input  logic [15:0]   frag_pos,
  input  logic [15:0]   payload_len,
  input  logic [31:0]   data_handle,
  input  logic          flush_after,
  input  tsa_pkg::cmd_t cmd,
  output tsa_pkg::sts_t sts,
  output logic [1:0]    seg_kind,
  output logic [31:0]   out_session,
  output logic [31:0]   out_seq,
  output logic [15:0]   out_frag_total,
  output logic [15:0]   out_frag_pos,
  output logic [31:0]   out_bitmap,
  output logic [15:0]   out_len,
  output logic [31:0]   out_handle,
  output logic          last_of_burst
);

  localparam int unsigned CNT_W  = $clog2(MAX_SEGS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_SEGS);

  // Latched request.
  logic [1:0]  r_type;
  logic [31:0] r_sess, r_seq, r_handle;
  logic [15:0] r_ftot, r_fpos, r_plen;
  logic        r_fa;

  // Control state.
  logic [15:0]       threshold;
  logic [CNT_W-1:0]  seg_count;
  logic [16:0]       bytes_used;
  logic              ack_open, frag_open;
  logic [ADDR_W-1:0] ack_slot, frag_slot, rd_idx;

  // Mirrors of the open ack entries.
  logic [31:0] ack_sess, ack_base, ack_bm;
  logic [31:0] f_sess, f_seq, f_bm;
  logic [15:0] f_tot, f_base;

  // Store.
  tsa_pkg::entry_t store [MAX_SEGS];
  logic [31:0]     store_bitmap [MAX_SEGS];
  tsa_pkg::entry_t rd_q;
  logic [31:0]     rd_bm;
  logic            rd_last;

  logic        plain;
  logic [16:0] seg_len;
  logic [31:0] ack_top, ack_off;
  logic [16:0] f_top;
  logic [15:0] f_off;
  logic        ack_hit, frag_hit;
  logic [31:0] ack_bm_new, f_bm_new, new_bm;
  logic        bm_we;
  logic [ADDR_W-1:0] bm_addr, wr_slot;
  logic [31:0] bm_wdata;
  tsa_pkg::entry_t new_entry;

  always_comb begin
    plain   = (r_ftot == 16'd1);
    wr_slot = seg_count[ADDR_W-1:0];
    if (r_type == tsa_pkg::REQ_DATA) seg_len = 17'(DATA_SEG_OVERHEAD) + {1'b0, r_plen};
    else if (plain)                  seg_len = 17'(ACK_SEG_SIZE);
    else                             seg_len = 17'(FRAG_ACK_SEG_SIZE);

    ack_top = ack_base + 32'(tsa_pkg::WIN);
    ack_off = r_seq - ack_base;
    ack_hit = ack_open && (ack_sess == r_sess) && (ack_base <= r_seq) && (ack_top > r_seq);
    f_top   = {1'b0, f_base} + 17'(tsa_pkg::WIN);
    f_off   = r_fpos - f_base;
    frag_hit = frag_open && (f_sess == r_sess) && (f_seq == r_seq) && (f_tot == r_ftot)
               && (f_base <= r_fpos) && (f_top > {1'b0, r_fpos});
    ack_bm_new = ack_bm | (32'd1 << ack_off[4:0]);
    f_bm_new   = f_bm | (32'd1 << f_off[4:0]);

    new_entry = '0;
    new_entry.kind = tsa_pkg::KIND_DATA;
    new_bm = '0;
    if (r_type == tsa_pkg::REQ_DATA) begin
      new_entry.seq        = r_seq;
      new_entry.frag_total = r_ftot;
      new_entry.frag_pos   = r_fpos;
      new_entry.len        = r_plen;
      new_entry.handle     = r_handle;
    end else if (plain) begin
      new_entry.kind    = tsa_pkg::KIND_ACK;
      new_entry.session = r_sess;
      new_entry.seq     = r_seq;
      new_bm            = 32'd1;
    end else begin
      new_entry.kind       = tsa_pkg::KIND_FRAG_ACK;
      new_entry.session    = r_sess;
      new_entry.seq        = r_seq;
      new_entry.frag_total = r_ftot;
      new_entry.frag_pos   = {r_fpos[15:5], 5'd0};
      new_bm               = 32'd1 << r_fpos[4:0];
    end

    bm_we    = cmd.add || cmd.merge;
    bm_addr  = wr_slot;
    bm_wdata = new_bm;
    if (cmd.merge) begin
      bm_addr  = plain ? ack_slot : frag_slot;
      bm_wdata = plain ? ack_bm_new : f_bm_new;
    end

    sts.req        = r_type;
    sts.merge      = (r_type == tsa_pkg::REQ_ACK) && (plain ? ack_hit : frag_hit);
    sts.pre_flush  = ({1'b0, bytes_used} + {1'b0, seg_len} > 18'(threshold))
                     || (seg_count >= CNT_W'(MAX_SEGS));
    sts.post_flush = ({1'b0, bytes_used} + 18'(MIN_SEG_SIZE) > 18'(threshold))
                     || (seg_count >= CNT_W'(MAX_SEGS)) || r_fa;
    sts.empty      = (seg_count == '0);
    sts.last       = rd_last;
  end

  // Request latch and store; payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_type   <= req_type;
      r_sess   <= session_id;
      r_seq    <= seq_num;
      r_ftot   <= frag_total;
      r_fpos   <= frag_pos;
      r_plen   <= payload_len;
      r_handle <= data_handle;
      r_fa     <= flush_after;
    end
    if (cmd.add) store[wr_slot] <= new_entry;
    if (bm_we) store_bitmap[bm_addr] <= bm_wdata;
    if (cmd.rd) begin
      rd_q    <= store[rd_idx];
      rd_bm   <= store_bitmap[rd_idx];
      rd_last <= (CNT_W'(rd_idx) + CNT_W'(1)) == seg_count;
    end
    if (cmd.merge) begin
      if (plain) ack_bm <= ack_bm_new;
      else       f_bm   <= f_bm_new;
    end
    if (cmd.add && r_type == tsa_pkg::REQ_ACK) begin
      if (plain) begin
        ack_sess <= r_sess;
        ack_base <= r_seq;
        ack_bm   <= new_bm;
      end else begin
        f_sess <= r_sess;
        f_seq  <= r_seq;
        f_tot  <= r_ftot;
        f_base <= {r_fpos[15:5], 5'd0};
        f_bm   <= new_bm;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= 16'd1400;
      seg_count  <= '0;
      bytes_used <= '0;
      ack_open   <= 1'b0;
      frag_open  <= 1'b0;
      ack_slot   <= '0;
      frag_slot  <= '0;
      rd_idx     <= '0;
    end else begin
      if (cfg_we) threshold <= cfg_data;
      if (cmd.step) rd_idx <= rd_idx + ADDR_W'(1);
      if (cmd.clear) begin
        seg_count  <= '0;
        bytes_used <= '0;
        ack_open   <= 1'b0;
        frag_open  <= 1'b0;
        rd_idx     <= '0;
      end else if (cmd.add) begin
        seg_count  <= seg_count + CNT_W'(1);
        bytes_used <= bytes_used + seg_len;
        if (r_type == tsa_pkg::REQ_ACK) begin
          if (plain) begin
            ack_open <= 1'b1;
            ack_slot <= wr_slot;
          end else begin
            frag_open <= 1'b1;
            frag_slot <= wr_slot;
          end
        end
      end
    end
  end

  assign seg_kind       = rd_q.kind;
  assign out_session    = rd_q.session;
  assign out_seq        = rd_q.seq;
  assign out_frag_total = rd_q.frag_total;
  assign out_frag_pos   = rd_q.frag_pos;
  assign out_bitmap     = rd_bm;
  assign out_len        = rd_q.len;
  assign out_handle     = rd_q.handle;
  assign last_of_burst  = rd_last;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CNT_W'(MAX_SEGS))
    else $error("segment count above store depth");
  a_add_room: assert property (@(posedge clk) disable iff (rst)
    cmd.add |-> seg_count < CNT_W'(MAX_SEGS))
    else $error("add into a full store");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> seg_count == '0 && !ack_open && !frag_open)
    else $error("flush left state behind");
`endif

endmodule

// ----- sv/tx_segment_aggregator_ack_coalesce_core.sv -----
// Top level of the transmit segment aggregator with ack coalescing.
// Instantiates tsa_ctrl and tsa_dpath; uses tsa_pkg for shared types.
//
//  channel  signals                        direction  purpose
//  cfg      cfg_valid/cfg_ready/cfg_data   in         packet byte budget write
//  in       in_valid/in_ready + fields     in         one request transaction
//  out      out_valid/out_ready + fields   out        one emitted segment
//
// A request passes through latch and decide when it merges into an open ack
// or is ignored, and through latch, decide, add and check when it only
// appends a segment. Each flushed segment takes a registered store read, then
// the output transaction. Reset is synchronous and active high; it empties
// the store and sets the threshold to 1400. A stalled output holds the
// block; no new request is taken until the whole burst of the current one
// has been delivered.
module tx_segment_aggregator_ack_coalesce_core #(
  parameter int unsigned MAX_SEGS          = 32,
  parameter int unsigned DATA_SEG_OVERHEAD = 12,
  parameter int unsigned ACK_SEG_SIZE      = 12,
  parameter int unsigned FRAG_ACK_SEG_SIZE = 16,
  parameter int unsigned MIN_SEG_SIZE      = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] session_id,
  input  logic [31:0] seq_num,
  input  logic [15:0] frag_total,
  input  logic [15:0] frag_pos,
  input  logic [15:0] payload_len,
  input  logic [31:0] data_handle,
  input  logic        flush_after,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  seg_kind,
  output logic [31:0] out_session,
  output logic [31:0] out_seq,
  output logic [15:0] out_frag_total,
  output logic [15:0] out_frag_pos,
  output logic [31:0] out_bitmap,
  output logic [15:0] out_len,
  output logic [31:0] out_handle,
  output logic        last_of_burst
);

  tsa_pkg::cmd_t cmd;
  tsa_pkg::sts_t sts;

  // The threshold register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsa_dpath #(
    .MAX_SEGS          (MAX_SEGS),
    .DATA_SEG_OVERHEAD (DATA_SEG_OVERHEAD),
    .ACK_SEG_SIZE      (ACK_SEG_SIZE),
    .FRAG_ACK_SEG_SIZE (FRAG_ACK_SEG_SIZE),
    .MIN_SEG_SIZE      (MIN_SEG_SIZE)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .session_id     (session_id),
    .seq_num        (seq_num),
    .frag_total     (frag_total),
    .frag_pos       (frag_pos),
    .payload_len    (payload_len),
    .data_handle    (data_handle),
    .flush_after    (flush_after),
    .cmd            (cmd),
    .sts            (sts),
    .seg_kind       (seg_kind),
    .out_session    (out_session),
    .out_seq        (out_seq),
    .out_frag_total (out_frag_total),
    .out_frag_pos   (out_frag_pos),
    .out_bitmap     (out_bitmap),
    .out_len        (out_len),
    .out_handle     (out_handle),
    .last_of_burst  (last_of_burst)
  );

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");
  a_no_out_when_ready: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output offered together");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_seq) && $stable(last_of_burst))
    else $error("stalled output transaction changed");
`endif

endmodule

// ----- tb/tb_tx_segment_aggregator_ack_coalesce_core.sv -----
// Testbench for tx_segment_aggregator_ack_coalesce_core: directed table plus
// random requests, checked against a built-in segment store predictor.
// Depends on tsa_pkg and the RTL of the block.
module tb_tx_segment_aggregator_ack_coalesce_core;

  localparam int NSEG       = 32;
  localparam int DATA_OVH   = 12;
  localparam int ACK_SIZE   = 12;
  localparam int FACK_SIZE  = 16;
  localparam int MIN_SIZE   = 8;
  localparam int CYCLE_CAP  = 1500000;
  localparam int DRAIN_WAIT = 12;

  // Idling profiles that the run walks through.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] session;
    logic [31:0] seq;
    logic [15:0] ftot;
    logic [15:0] fpos;
    logic [15:0] plen;
    logic [31:0] handle;
    logic        fa;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] session;
    logic [31:0] seq;
    logic [15:0] ftot;
    logic [15:0] fpos;
    logic [31:0] bitmap;
    logic [15:0] len;
    logic [31:0] handle;
    logic        last;
  } segment_t;

  // A row of the directed table. When typed is set, the row's outcome is
  // written here: either nothing, or one data segment that echoes the row.
  typedef struct {
    request_t rq;
    bit       typed;
    int       n_segs;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [31:0] session_id = '0;
  logic [31:0] seq_num = '0;
  logic [15:0] frag_total = '0;
  logic [15:0] frag_pos = '0;
  logic [15:0] payload_len = '0;
  logic [31:0] data_handle = '0;
  logic        flush_after = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  seg_kind;
  logic [31:0] out_session;
  logic [31:0] out_seq;
  logic [15:0] out_frag_total;
  logic [15:0] out_frag_pos;
  logic [31:0] out_bitmap;
  logic [15:0] out_len;
  logic [31:0] out_handle;
  logic        last_of_burst;

  tx_segment_aggregator_ack_coalesce_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .session_id(session_id), .seq_num(seq_num),
    .frag_total(frag_total), .frag_pos(frag_pos), .payload_len(payload_len),
    .data_handle(data_handle), .flush_after(flush_after),
    .out_valid(out_valid), .out_ready(out_ready),
    .seg_kind(seg_kind), .out_session(out_session), .out_seq(out_seq),
    .out_frag_total(out_frag_total), .out_frag_pos(out_frag_pos),
    .out_bitmap(out_bitmap), .out_len(out_len), .out_handle(out_handle),
    .last_of_burst(last_of_burst)
  );

  always #10 clk = ~clk;

  // Mirror of the block's state: the segment store, its fill level and byte
  // count, and the slots of the currently open ack and fragment ack.
  segment_t    store_mirror [NSEG];
  int          fill;
  int          bytes_held;
  bit          ack_live;
  int          ack_at;
  bit          fack_live;
  int          fack_at;
  logic [15:0] threshold;

  segment_t pending_segs[$];   // segments the block still owes us
  int       idle_mode;
  int       errors;
  int       mismatches;
  int       cycles;
  int       seg_seen;
  int       bursts_seen;
  int       reqs_sent;

  // Copy the whole store into the pending list as one burst and empty it.
  // Flushing also closes both open acks.
  task automatic flush_store();
    for (int i = 0; i < fill; i++) begin
      segment_t s;
      s = store_mirror[i];
      s.last = (i + 1 == fill);
      pending_segs.push_back(s);
    end
    fill = 0;
    bytes_held = 0;
    ack_live = 0;
    fack_live = 0;
  endtask

  task automatic flush_if_over(int incoming);
    if (bytes_held + incoming > int'(threshold) || fill >= NSEG) flush_store();
  endtask

  // Reserve a fresh, zeroed slot, flushing first when it would not fit.
  task automatic open_slot(int seg_len, output int slot);
    flush_if_over(seg_len);
    slot = (fill >= NSEG) ? NSEG - 1 : fill;
    store_mirror[slot] = '{default: '0};
  endtask

  task automatic close_add(int seg_len, logic fa);
    fill++;
    bytes_held += seg_len;
    flush_if_over(MIN_SIZE);
    if (fa) flush_store();
  endtask

  // Work out the segments that one accepted request releases.
  task automatic aggregate_request(request_t r);
    int          slot;
    int          seg_len;
    logic [31:0] base;
    logic [31:0] top;
    int          fbase;
    case (r.req)
      tsa_pkg::REQ_DATA: begin
        seg_len = DATA_OVH + int'(r.plen);
        open_slot(seg_len, slot);
        store_mirror[slot].kind   = tsa_pkg::KIND_DATA;
        store_mirror[slot].seq    = r.seq;
        store_mirror[slot].ftot   = r.ftot;
        store_mirror[slot].fpos   = r.fpos;
        store_mirror[slot].len    = r.plen;
        store_mirror[slot].handle = r.handle;
        close_add(seg_len, r.fa);
      end
      tsa_pkg::REQ_ACK: begin
        if (r.ftot == 16'd1) begin
          if (ack_live) begin
            base = store_mirror[ack_at].seq;
            top  = base + 32'd32;   // wraps at 2^32, which blocks any merge
            if (store_mirror[ack_at].session == r.session && base <= r.seq &&
                top > r.seq) begin
              store_mirror[ack_at].bitmap[r.seq - base] = 1'b1;
              return;
            end
          end
          seg_len = ACK_SIZE;
          open_slot(seg_len, slot);
          store_mirror[slot].kind    = tsa_pkg::KIND_ACK;
          store_mirror[slot].session = r.session;
          store_mirror[slot].seq     = r.seq;
          store_mirror[slot].bitmap  = 32'd1;
          ack_live = 1;
          ack_at   = slot;
        end else begin
          if (fack_live) begin
            fbase = int'(store_mirror[fack_at].fpos);
            if (store_mirror[fack_at].session == r.session &&
                store_mirror[fack_at].seq == r.seq &&
                store_mirror[fack_at].ftot == r.ftot &&
                fbase <= int'(r.fpos) && fbase + 32 > int'(r.fpos)) begin
              store_mirror[fack_at].bitmap[int'(r.fpos) - fbase] = 1'b1;
              return;
            end
          end
          seg_len = FACK_SIZE;
          open_slot(seg_len, slot);
          store_mirror[slot].kind    = tsa_pkg::KIND_FRAG_ACK;
          store_mirror[slot].session = r.session;
          store_mirror[slot].seq     = r.seq;
          store_mirror[slot].ftot    = r.ftot;
          store_mirror[slot].fpos    = {r.fpos[15:5], 5'd0};
          store_mirror[slot].bitmap  = 32'd1 << r.fpos[4:0];
          fack_live = 1;
          fack_at   = slot;
        end
        close_add(seg_len, r.fa);
      end
      tsa_pkg::REQ_TIMEOUT: flush_store();
      default: ;  // the unused request code is dropped
    endcase
  endtask

  function automatic bit stall_now(bit sender_side);
    bit hit;
    int pct;
    hit = (idle_mode == IDLE_BOTH) ||
          (sender_side ? idle_mode == IDLE_SEND : idle_mode == IDLE_RECV);
    pct = (idle_mode == IDLE_BOTH) ? 24 : 75;
    return hit && ($urandom_range(99) < pct);
  endfunction

  // Receiver side: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    out_ready <= !rst && !stall_now(1'b0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d segments still owed", cycles,
               pending_segs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_bad(string what, logic [31:0] exp_v, logic [31:0] got_v);
    errors++;
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on segment %0d, %s: expected %h, got %h", seg_seen, what,
               exp_v, got_v);
  endtask

  // Output monitor: every segment transaction is compared with the oldest
  // segment the predictor has queued.
  always @(posedge clk) begin
    segment_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_segs.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected segment kind %0d seq %h", seg_kind, out_seq);
      end else begin
        e = pending_segs.pop_front();
        if (seg_kind != e.kind) report_bad("seg_kind", 32'(e.kind), 32'(seg_kind));
        if (out_session != e.session) report_bad("out_session", e.session, out_session);
        if (out_seq != e.seq) report_bad("out_seq", e.seq, out_seq);
        if (out_frag_total != e.ftot)
          report_bad("out_frag_total", 32'(e.ftot), 32'(out_frag_total));
        if (out_frag_pos != e.fpos)
          report_bad("out_frag_pos", 32'(e.fpos), 32'(out_frag_pos));
        if (out_bitmap != e.bitmap) report_bad("out_bitmap", e.bitmap, out_bitmap);
        if (out_len != e.len) report_bad("out_len", 32'(e.len), 32'(out_len));
        if (out_handle != e.handle) report_bad("out_handle", e.handle, out_handle);
        if (last_of_burst != e.last)
          report_bad("last_of_burst", 32'(e.last), 32'(last_of_burst));
      end
      seg_seen++;
      if (last_of_burst) bursts_seen++;
    end
  end

  // Present one request and hold it until the block takes it. The caller is
  // at a falling edge on entry and exit. Typed rows replace the predicted
  // segments with the ones written into the table.
  task automatic send_request(request_t r, bit typed = 0, int n_segs = 0);
    int       mark;
    segment_t s;
    while (stall_now(1'b1)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    req_type    = r.req;
    session_id  = r.session;
    seq_num     = r.seq;
    frag_total  = r.ftot;
    frag_pos    = r.fpos;
    payload_len = r.plen;
    data_handle = r.handle;
    flush_after = r.fa;
    do @(posedge clk); while (!in_ready);
    mark = pending_segs.size();
    aggregate_request(r);
    if (typed) begin
      while (pending_segs.size() > mark) void'(pending_segs.pop_back());
      if (n_segs == 1) begin
        s = '{kind: tsa_pkg::KIND_DATA, session: '0, seq: r.seq, ftot: r.ftot,
              fpos: r.fpos, bitmap: '0, len: r.plen, handle: r.handle, last: 1'b1};
        pending_segs.push_back(s);
      end
    end
    reqs_sent++;
    @(negedge clk);
  endtask

  // Let every owed segment come out, then give a request that released
  // nothing (a merge, say) time to finish inside the block.
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (pending_segs.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random requests are mostly well formed: acks and fragment acks reuse a
  // few sessions and land near the previous sequence so that they merge,
  // while a share of fully random fields keeps every bit moving.
  logic [31:0] sess_pool [4];
  logic [31:0] last_seq;
  logic [15:0] last_fpos;
  logic [15:0] last_ftot;

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    r.session = sess_pool[$urandom_range(3)];
    r.seq     = $urandom();
    r.ftot    = 16'($urandom());
    r.fpos    = 16'($urandom());
    r.handle  = $urandom();
    r.plen    = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(200));
    r.fa      = ($urandom_range(99) < 8);
    if (pick < 38) begin
      r.req = tsa_pkg::REQ_DATA;
    end else if (pick < 68) begin
      r.req  = tsa_pkg::REQ_ACK;
      r.ftot = 16'd1;
      if ($urandom_range(3) != 0) r.seq = last_seq + $urandom_range(40);
    end else if (pick < 90) begin
      r.req = tsa_pkg::REQ_ACK;
      if ($urandom_range(4) != 0) begin
        r.seq  = last_seq;
        r.ftot = last_ftot;
        r.fpos = last_fpos + 16'($urandom_range(40));
      end
    end else if (pick < 97) begin
      r.req = tsa_pkg::REQ_TIMEOUT;
    end else begin
      r.req = tsa_pkg::REQ_UNUSED;
    end
    if ($urandom_range(15) == 0) r.session = $urandom();
    return r;
  endfunction

  row_t directed [$];

  function automatic row_t mk_row(logic [1:0] req, logic [31:0] sess, logic [31:0] seq,
                                  logic [15:0] ftot, logic [15:0] fpos, logic [15:0] plen,
                                  logic [31:0] handle, logic fa, bit typed = 0, int n = 0);
    row_t w;
    w.rq = '{req: req, session: sess, seq: seq, ftot: ftot, fpos: fpos, plen: plen,
             handle: handle, fa: fa};
    w.typed  = typed;
    w.n_segs = n;
    return w;
  endfunction

  initial begin
    logic [15:0] phase_thr [5];
    request_t    r;
    int          per_phase;
    int          sent;

    fill = 0;
    bytes_held = 0;
    ack_live = 0;
    ack_at = 0;
    fack_live = 0;
    fack_at = 0;
    threshold = 16'd1400;
    idle_mode = IDLE_NONE;
    reqs_sent = 0;
    last_seq = 32'd1000;
    last_ftot = 16'd20;
    last_fpos = 16'd0;
    sess_pool = '{32'd7, 32'hffff_ffff, 32'h1234_5678, 32'd0};

    // Directed part, run at the reset threshold of 1400 bytes.
    directed.push_back(mk_row(tsa_pkg::REQ_TIMEOUT, '0, '0, '0, '0, '0, '0, 1'b0, 1, 0));
    directed.push_back(mk_row(tsa_pkg::REQ_UNUSED, '1, '1, '1, '1, '1, '1, 1'b1, 1, 0));
    directed.push_back(mk_row(tsa_pkg::REQ_DATA, '0, '0, '0, '0, '0, '0, 1'b1, 1, 1));
    // An oversized data segment is stored and then flushed on its own.
    directed.push_back(mk_row(tsa_pkg::REQ_DATA, '1, '1, '1, '1, '1, '1, 1'b0, 1, 1));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd5, 32'd100, 16'd1, '0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd5, 32'd131, 16'd1, '0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd5, 32'd132, 16'd1, '0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd5, 32'd131, 16'd1, '0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd6, 32'd133, 16'd1, '0, '0, '0, 1'b0));
    // Ack base near the top of the sequence space never takes a merge.
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd6, 32'hffff_ffe8, 16'd1, '0, '0, '0,
                              1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd6, 32'hffff_ffff, 16'd1, '0, '0, '0,
                              1'b0));
    // Fragment acks, including a zero fragment count.
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd9, 32'd50, 16'd0, 16'd37, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd9, 32'd50, 16'd0, 16'd63, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd9, 32'd50, 16'd0, 16'd64, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd9, 32'd50, 16'd5, 16'hffff, '0, '0,
                              1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, '1, '1, '1, 16'hffe0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_DATA, '0, 32'd77, 16'd3, 16'd1, 16'd40, 32'hdead,
                              1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_TIMEOUT, '0, '0, '0, '0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_TIMEOUT, '0, '0, '0, '0, '0, '0, 1'b0, 1, 0));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd3, 32'd8, 16'd1, '0, '0, '0, 1'b1));
    directed.push_back(mk_row(tsa_pkg::REQ_ACK, 32'd3, 32'd9, 16'd1, '0, '0, '0, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_DATA, '0, 32'd1, '0, '0, 16'd1300, 32'd1, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_DATA, '0, 32'd2, '0, '0, 16'd90, 32'd2, 1'b0));
    directed.push_back(mk_row(tsa_pkg::REQ_TIMEOUT, '0, '0, '0, '0, '0, '0, 1'b0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_request(directed[i].rq, directed[i].typed, directed[i].n_segs);

    // Random part: each phase gets its own threshold and one of the four idling profiles.
    phase_thr = '{16'd0, 16'hffff, 16'd1400, 16'($urandom()), 16'd120};
    per_phase = 80;
    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thr[p]);
      idle_mode = p % 4;
      sent = 0;
      while (sent < per_phase) begin
        r = random_request();
        // The top phase budget allows a full store; feed it small data.
        if (phase_thr[p] == 16'hffff && r.req == tsa_pkg::REQ_DATA)
          r.plen = 16'($urandom_range(20));
        send_request(r);
        if (r.req == tsa_pkg::REQ_ACK) begin
          last_seq = r.seq;
          last_ftot = r.ftot;
          last_fpos = r.fpos;
        end
        if (r.req != tsa_pkg::REQ_UNUSED) sent++;
      end
    end

    // Close out any open store and wait for everything owed.
    idle_mode = IDLE_NONE;
    r = '{req: tsa_pkg::REQ_TIMEOUT, default: '0};
    send_request(r);
    wait_quiet();

    $display("Ran %0d requests over five thresholds and four idling profiles;", reqs_sent);
    $display("checked %0d segments in %0d bursts, %0d mismatches.", seg_seen, bursts_seen,
             mismatches);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
